// ===== rtl/core/mstw_pkg.sv =====
package mstw_pkg;

  localparam int SUM_W    = 24;
  localparam int STATUS_W = 2;
  localparam int VCNT_W   = 7;
  localparam int VIDX_W   = 6;
  localparam int IN_W_W   = 16;

  localparam logic [SUM_W-1:0]    SUM_MAX   = '1;
  localparam logic [VCNT_W-1:0]   VCNT_RST  = 7'd64;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP   = 2'd2;

endpackage

// ===== rtl/core/mstw_edge_mem.sv =====
module mstw_edge_mem #(
  parameter int DEPTH = 256,
  parameter int DW    = 28
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mstw_uf_mem.sv =====
// Union-find table: {size, parent} per vertex. Entries not yet written read as
// their reset value (parent = self, size = 1), tracked by one valid bit each.
module mstw_uf_mem #(
  parameter int NV = 64,
  parameter int VW = 6,
  parameter int SW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          we,
  input  logic [VW-1:0] waddr,
  input  logic [VW-1:0] wparent,
  input  logic [SW-1:0] wsize,
  input  logic [VW-1:0] raddr,
  output logic [VW-1:0] rparent,
  output logic [SW-1:0] rsize
);

  logic [VW+SW-1:0] mem [NV];
  logic [NV-1:0]    valid;
  logic [VW+SW-1:0] q;
  logic             q_valid;
  logic [VW-1:0]    q_addr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wsize, wparent};
    end
    q      <= mem[raddr];
    q_addr <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid   <= '0;
      q_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      q_valid <= valid[raddr];
    end
  end

  assign rparent = q_valid ? q[VW-1:0] : q_addr;
  assign rsize   = q_valid ? q[VW+SW-1:VW] : SW'(1);

endmodule

// ===== rtl/core/minimum_spanning_tree_weight_unit.sv =====
// Edge load: one edge transfer per cycle while busy is low; non-final edges give no result.
// Final edge: insertion sort in the edge memory, then the stored edges are processed in
// sorted order, each one walking the find paths of its endpoints and joining the sets.
// done pulses for exactly one cycle with the result; busy drops the cycle after it.
// The receiver cannot stall.
// Synchronous reset: empty edge list, no errors, vertex_count 64, trivial sets.
module minimum_spanning_tree_weight_unit #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [mstw_pkg::VIDX_W-1:0]     first_vertex,
  input  logic [mstw_pkg::VIDX_W-1:0]     second_vertex,
  input  logic [mstw_pkg::IN_W_W-1:0]     edge_weight,
  input  logic                            final_edge,
  input  logic                            cfg_wr_en,
  input  logic [mstw_pkg::VCNT_W-1:0]     cfg_wr_data,
  output logic                            done,
  output logic [mstw_pkg::SUM_W-1:0]      tree_weight,
  output logic [mstw_pkg::STATUS_W-1:0]   status
);
  import mstw_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int SW = $clog2(MAX_VERTICES + 1);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int FW = $clog2(MAX_EDGES + 1);
  localparam int DW = WEIGHT_BITS + 2 * VW;
  localparam int AW = (WEIGHT_BITS + 1 > SUM_W + 1) ? WEIGHT_BITS + 1 : SUM_W + 1;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RI   = 11'b00000000010,
    S_LT   = 11'b00000000100,
    S_CMP  = 11'b00000001000,
    S_PUT  = 11'b00000010000,
    K_RE   = 11'b00000100000,
    K_LE   = 11'b00001000000,
    F_CK   = 11'b00010000000,
    C_CK   = 11'b00100000000,
    U_ONE  = 11'b01000000000,
    U_TWO  = 11'b10000000000
  } state_t;

  state_t            state;
  logic              done_q;
  logic [VCNT_W-1:0] vcnt;
  logic [FW-1:0]     fill;
  logic [STATUS_W-1:0] err;
  logic [FW-1:0]     i, j;
  logic [DW-1:0]     tword;
  logic [VW-1:0]     ea, eb, cur, root, ra;
  logic [WEIGHT_BITS-1:0] ew;
  logic [SW-1:0]     rsize, sa;
  logic              phase;
  logic [SUM_W-1:0]  sum;

  // edge memory
  logic          e_we;
  logic [EW-1:0] e_waddr, e_raddr;
  logic [DW-1:0] e_wdata, e_rdata;

  // union-find table
  logic          u_we, u_clear;
  logic [VW-1:0] u_waddr, u_wparent, u_raddr, u_rparent;
  logic [SW-1:0] u_wsize, u_rsize;

  logic accept, oob, full;
  logic [DW-1:0] in_word;
  logic [AW-1:0] add;
  logic [VW-1:0] start_v;

  mstw_edge_mem #(.DEPTH(MAX_EDGES), .DW(DW)) u_edges (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  mstw_uf_mem #(.NV(MAX_VERTICES), .VW(VW), .SW(SW)) u_sets (
    .clk(clk), .rst(rst), .clear(u_clear), .we(u_we), .waddr(u_waddr),
    .wparent(u_wparent), .wsize(u_wsize), .raddr(u_raddr),
    .rparent(u_rparent), .rsize(u_rsize)
  );

  assign busy        = (state != S_IDLE) || done_q;
  assign done        = done_q;
  assign tree_weight = sum;
  assign status      = err;
  assign accept      = start && !busy;

  always_comb begin
    if (32'(vcnt) > MAX_VERTICES) begin
      oob = (32'(first_vertex) >= MAX_VERTICES) || (32'(second_vertex) >= MAX_VERTICES);
    end else begin
      oob = ({1'b0, first_vertex} >= vcnt) || ({1'b0, second_vertex} >= vcnt);
    end
  end

  assign full    = (fill == FW'(MAX_EDGES));
  // word order {w, a, b}: one unsigned compare gives the sort order
  assign in_word = {WEIGHT_BITS'(edge_weight), VW'(first_vertex), VW'(second_vertex)};
  assign add     = AW'(sum) + AW'(ew);
  assign start_v = phase ? eb : ea;

  always_comb begin
    e_we      = 1'b0;
    e_waddr   = fill[EW-1:0];
    e_wdata   = in_word;
    e_raddr   = i[EW-1:0];
    u_we      = 1'b0;
    u_waddr   = cur;
    u_wparent = root;
    u_wsize   = u_rsize;
    u_raddr   = cur;
    unique case (state)
      S_IDLE: begin
        e_we = accept && !oob && !full;
      end
      S_LT: begin
        e_raddr = EW'(i - FW'(1));
      end
      S_CMP: begin
        e_we    = 1'b1;
        e_waddr = j[EW-1:0];
        e_wdata = (tword < e_rdata) ? e_rdata : tword;
        e_raddr = EW'(j - FW'(2));
      end
      S_PUT: begin
        e_we    = 1'b1;
        e_waddr = j[EW-1:0];
        e_wdata = tword;
      end
      K_LE: begin
        u_raddr = e_rdata[2*VW-1:VW];
      end
      F_CK: begin
        u_raddr = (u_rparent == cur) ? start_v : u_rparent;
      end
      C_CK: begin
        if (u_rparent == root) begin
          u_raddr = eb;
        end else begin
          u_we    = 1'b1;
          u_raddr = u_rparent;
        end
      end
      U_ONE: begin
        u_we = (ra != root);
        if (sa < rsize) begin
          u_waddr = ra;    u_wparent = root; u_wsize = sa;
        end else begin
          u_waddr = root;  u_wparent = ra;   u_wsize = rsize;
        end
      end
      U_TWO: begin
        u_we    = 1'b1;
        u_wsize = SW'(sa + rsize);
        if (sa < rsize) begin
          u_waddr = root;  u_wparent = root;
        end else begin
          u_waddr = ra;    u_wparent = ra;
        end
      end
      default: begin
      end
    endcase
  end

  assign u_clear = done_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done_q <= 1'b0;
      vcnt   <= VCNT_RST;
      fill   <= '0;
      err    <= ST_OK;
    end else begin
      done_q <= 1'b0;
      if (cfg_wr_en) begin
        vcnt <= cfg_wr_data;
      end
      if (done_q) begin
        fill <= '0;
        err  <= ST_OK;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (oob) begin
              if (err == ST_OK) begin
                err <= ST_RANGE;
              end
            end else if (full) begin
              err <= ST_DROP;
            end else begin
              fill <= fill + FW'(1);
            end
            if (final_edge) begin
              i     <= FW'(1);
              sum   <= '0;
              state <= S_RI;
            end
          end
        end
        S_RI: begin
          if (i >= fill) begin
            i     <= '0;
            state <= K_RE;
          end else begin
            state <= S_LT;
          end
        end
        S_LT: begin
          tword <= e_rdata;
          j     <= i;
          state <= S_CMP;
        end
        S_CMP: begin
          if (tword < e_rdata) begin
            j <= j - FW'(1);
            if (j == FW'(1)) begin
              state <= S_PUT;
            end
          end else begin
            i     <= i + FW'(1);
            state <= S_RI;
          end
        end
        S_PUT: begin
          i     <= i + FW'(1);
          state <= S_RI;
        end
        K_RE: begin
          if (i >= fill) begin
            done_q <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= K_LE;
          end
        end
        K_LE: begin
          ew    <= e_rdata[DW-1:2*VW];
          ea    <= e_rdata[2*VW-1:VW];
          eb    <= e_rdata[VW-1:0];
          cur   <= e_rdata[2*VW-1:VW];
          phase <= 1'b0;
          state <= F_CK;
        end
        F_CK: begin
          if (u_rparent == cur) begin
            root  <= cur;
            rsize <= u_rsize;
            cur   <= start_v;
            state <= C_CK;
          end else begin
            cur <= u_rparent;
          end
        end
        C_CK: begin
          if (u_rparent == root) begin
            if (!phase) begin
              ra    <= root;
              sa    <= rsize;
              phase <= 1'b1;
              cur   <= eb;
              state <= F_CK;
            end else begin
              state <= U_ONE;
            end
          end else begin
            cur <= u_rparent;
          end
        end
        U_ONE: begin
          if (ra == root) begin
            i     <= i + FW'(1);
            state <= K_RE;
          end else begin
            sum   <= (add > AW'(SUM_MAX)) ? SUM_MAX : add[SUM_W-1:0];
            state <= U_TWO;
          end
        end
        U_TWO: begin
          i     <= i + FW'(1);
          state <= K_RE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/mstw_checker.sv =====
module mstw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          final_edge,
  input logic                          done,
  input logic [mstw_pkg::STATUS_W-1:0] status
);
  import mstw_pkg::*;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result shown while idle");

  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && final_edge |=> busy)
    else $error("final edge did not start computation");

  a_edge_idle: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !final_edge |=> !busy && !done)
    else $error("non-final edge caused work or a result");

  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_RANGE || status == ST_DROP))
    else $error("bad status code");

endmodule

bind minimum_spanning_tree_weight_unit mstw_checker u_mstw_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .final_edge(final_edge),
  .done(done), .status(status)
);
